// File: design/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

    localparam int BALLS_DEF = 64;

    localparam int DIFF_W = 33;
    localparam int RSUM_W = 25;
    localparam int MOP_W  = 33;
    localparam int PROD_W = 2 * MOP_W;
    localparam int SQIN_W = 52;
    localparam int ROOT_W = SQIN_W / 2;
    localparam int DEN_W  = ROOT_W + 1;
    localparam int QUOT_W = PROD_W + 1;
    localparam int SUM_W  = QUOT_W + 1;

    localparam logic [DEN_W-1:0] DIST_TENTH = DEN_W'(6554);

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic        [23:0] rad;
    } ball_t;

    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_WRITE_IN,
        ACT_LOAD_A,
        ACT_LOAD_B,
        ACT_DIFF,
        ACT_DIFF2,
        ACT_SQRT,
        ACT_OV,
        ACT_DIV_DEN,
        ACT_DIV_R,
        ACT_UPD_XI,
        ACT_UPD_YI,
        ACT_UPD_XJ,
        ACT_UPD_YJ,
        ACT_UPD_VXI,
        ACT_UPD_VYI,
        ACT_UPD_VXJ,
        ACT_UPD_VYJ,
        ACT_COMMIT,
        ACT_WRITE_A,
        ACT_WRITE_B,
        ACT_OUT
    } act_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_DXDX,
        MUL_DYDY,
        MUL_RR,
        MUL_DXOV,
        MUL_DYOV,
        MUL_AIX,
        MUL_BJX,
        MUL_AIY,
        MUL_BJY,
        MUL_AJX,
        MUL_BIX,
        MUL_AJY,
        MUL_BIY
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        act_t     act;
        mul_sel_t mul;
        acc_op_t  acc;
        logic     last;
    } cmd_t;

    typedef struct packed {
        logic out_of_range;
        logic far;
        logic sqrt_busy;
        logic div_busy;
        logic r_zero;
        logic out_busy;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic in_range;
        in_range = (&v[SUM_W-1:31]) || !(|v[SUM_W-1:31]);
        if (in_range)
        begin
            return v[31:0];
        end
        else if (v[SUM_W-1])
        begin
            return 32'sh8000_0000;
        end
        else
        begin
            return 32'sh7fff_ffff;
        end
    endfunction

endpackage

`default_nettype wire

// File: design/pcc_in_if.sv
`default_nettype none

interface pcc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic        [23:0] rad;
    logic               final_item;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, rad, final_item, input ready);
    modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, rad, final_item, output ready);
endinterface

`default_nettype wire

// File: design/pcc_out_if.sv
`default_nettype none

interface pcc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic        [23:0] out_rad;
    logic               out_last;

    modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, out_rad,
                    out_last, input ready);
    modport sink   (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, out_rad,
                    out_last, output ready);
endinterface

`default_nettype wire

// File: design/pcc_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle, truncates toward zero
module pcc_div #(
    parameter int NW  = pcc_pkg::PROD_W,
    parameter int DVW = pcc_pkg::DEN_W
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [NW-1:0] dividend,
    input  wire logic        [DVW-1:0] divisor,
    output logic                      busy,
    output logic signed [NW:0]        quot
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    mag_reg;
    logic [DVW-1:0]   rem_reg;
    logic [DVW-1:0]   dvs_reg;
    logic             neg_reg;
    logic [DVW:0]     rem_sh;
    logic             qbit;

    assign rem_sh = {rem_reg, mag_reg[NW-1]};
    assign qbit   = rem_sh >= {1'b0, dvs_reg};
    assign busy   = cnt_reg != '0;
    assign quot   = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(NW);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[NW-1];
            mag_reg <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy)
        begin
            rem_reg <= qbit ? DVW'(rem_sh - {1'b0, dvs_reg}) : DVW'(rem_sh);
            mag_reg <= {mag_reg[NW-2:0], qbit};
        end
    end

endmodule

`default_nettype wire

// File: design/pcc_sqrt.sv
`default_nettype none

// digit-by-digit integer square root, one root bit per cycle
module pcc_sqrt #(
    parameter int IW = pcc_pkg::SQIN_W,
    parameter int OW = IW / 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [IW-1:0] radicand,
    output logic               busy,
    output logic [OW-1:0]      root
);

    localparam int CNT_W = $clog2(OW + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [IW-1:0]    sh_reg;
    logic [OW-1:0]    rem_reg;
    logic [OW-1:0]    root_reg;
    logic [OW+1:0]    rem_sh;
    logic [OW+1:0]    trial;
    logic             take;

    assign rem_sh = {rem_reg, sh_reg[IW-1:IW-2]};
    assign trial  = {root_reg, 2'b01};
    assign take   = rem_sh >= trial;
    assign busy   = cnt_reg != '0;
    assign root   = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(OW);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg   <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy)
        begin
            sh_reg   <= {sh_reg[IW-3:0], 2'b00};
            rem_reg  <= take ? OW'(rem_sh - trial) : OW'(rem_sh);
            root_reg <= {root_reg[OW-2:0], take};
        end
    end

endmodule

`default_nettype wire

// File: design/pcc_datapath.sv
`default_nettype none

module pcc_datapath #(
    parameter int BALLS = pcc_pkg::BALLS_DEF,
    parameter int AW    = $clog2(BALLS)
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pcc_pkg::cmd_t  cmd,
    input  wire logic [AW-1:0]  addr,
    input  wire pcc_pkg::ball_t in_word,
    output pcc_pkg::status_t    status,
    output pcc_pkg::ball_t      out_word,
    output logic                out_last,
    output logic                out_valid,
    input  wire logic           out_ready
);

    localparam int DW = pcc_pkg::DIFF_W;
    localparam int RS = pcc_pkg::RSUM_W;
    localparam int MW = pcc_pkg::MOP_W;
    localparam int PW = pcc_pkg::PROD_W;
    localparam int NW = pcc_pkg::DEN_W;
    localparam int QW = pcc_pkg::QUOT_W;
    localparam int SW = pcc_pkg::SUM_W;

    pcc_pkg::ball_t mem [BALLS];
    pcc_pkg::ball_t rd_reg;
    pcc_pkg::ball_t a_reg;
    pcc_pkg::ball_t b_reg;
    pcc_pkg::ball_t wdata;
    pcc_pkg::ball_t out_reg;
    logic           we;
    logic           out_last_reg;
    logic           out_valid_reg;

    logic signed [DW-1:0] dx_reg;
    logic signed [DW-1:0] dy_reg;
    logic        [RS-1:0] r_reg;
    logic        [RS-1:0] ov_reg;
    logic        [NW-1:0] den_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [31:0]   nvxi_reg;
    logic signed [31:0]   nvyi_reg;
    logic signed [31:0]   nvxj_reg;
    logic signed [31:0]   nvyj_reg;

    logic signed [MW-1:0] opa;
    logic signed [MW-1:0] opb;
    logic signed [RS-1:0] rdiff;
    logic        [DW-1:0] adx;
    logic        [DW-1:0] ady;

    logic                 div_start;
    logic signed [PW-1:0] div_num;
    logic        [NW-1:0] div_den;
    logic                 div_busy;
    logic signed [QW-1:0] quot;
    logic signed [SW-1:0] quot_x;
    logic                 sqrt_start;
    logic                 sqrt_busy;
    logic [pcc_pkg::ROOT_W-1:0] root;

    assign rdiff = $signed({1'b0, a_reg.rad}) - $signed({1'b0, b_reg.rad});
    assign quot_x = {quot[QW-1], quot};

    always_comb
    begin
        opa = '0;
        opb = '0;
        case (cmd.mul)
            pcc_pkg::MUL_DXDX:
            begin
                opa = dx_reg;
                opb = dx_reg;
            end
            pcc_pkg::MUL_DYDY:
            begin
                opa = dy_reg;
                opb = dy_reg;
            end
            pcc_pkg::MUL_RR:
            begin
                opa = $signed(MW'(r_reg));
                opb = $signed(MW'(r_reg));
            end
            pcc_pkg::MUL_DXOV:
            begin
                opa = dx_reg;
                opb = $signed(MW'(ov_reg));
            end
            pcc_pkg::MUL_DYOV:
            begin
                opa = dy_reg;
                opb = $signed(MW'(ov_reg));
            end
            pcc_pkg::MUL_AIX:
            begin
                opa = MW'(rdiff);
                opb = MW'(a_reg.vel_x);
            end
            pcc_pkg::MUL_BJX:
            begin
                opa = $signed(MW'({b_reg.rad, 1'b0}));
                opb = MW'(b_reg.vel_x);
            end
            pcc_pkg::MUL_AIY:
            begin
                opa = MW'(rdiff);
                opb = MW'(a_reg.vel_y);
            end
            pcc_pkg::MUL_BJY:
            begin
                opa = $signed(MW'({b_reg.rad, 1'b0}));
                opb = MW'(b_reg.vel_y);
            end
            pcc_pkg::MUL_AJX:
            begin
                opa = MW'(-rdiff);
                opb = MW'(b_reg.vel_x);
            end
            pcc_pkg::MUL_BIX:
            begin
                opa = $signed(MW'({a_reg.rad, 1'b0}));
                opb = MW'(a_reg.vel_x);
            end
            pcc_pkg::MUL_AJY:
            begin
                opa = MW'(-rdiff);
                opb = MW'(b_reg.vel_y);
            end
            pcc_pkg::MUL_BIY:
            begin
                opa = $signed(MW'({a_reg.rad, 1'b0}));
                opb = MW'(a_reg.vel_y);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        wdata = a_reg;
        case (cmd.act)
            pcc_pkg::ACT_WRITE_IN:
            begin
                we    = 1'b1;
                wdata = in_word;
            end
            pcc_pkg::ACT_WRITE_A:
            begin
                we    = 1'b1;
                wdata = a_reg;
            end
            pcc_pkg::ACT_WRITE_B:
            begin
                we    = 1'b1;
                wdata = b_reg;
            end
            default:
            begin
                we    = 1'b0;
                wdata = a_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rd_reg <= mem[addr];
    end

    assign div_start  = cmd.act == pcc_pkg::ACT_DIV_DEN || cmd.act == pcc_pkg::ACT_DIV_R;
    assign div_num    = (cmd.act == pcc_pkg::ACT_DIV_R) ? acc_reg : prod_reg;
    assign div_den    = (cmd.act == pcc_pkg::ACT_DIV_R) ? NW'(r_reg) : den_reg;
    assign sqrt_start = cmd.act == pcc_pkg::ACT_SQRT;

    pcc_div #(
        .NW  (PW),
        .DVW (NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quot     (quot)
    );

    pcc_sqrt #(
        .IW (pcc_pkg::SQIN_W),
        .OW (pcc_pkg::ROOT_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_reg[pcc_pkg::SQIN_W-1:0]),
        .busy     (sqrt_busy),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.mul != pcc_pkg::MUL_NONE)
        begin
            prod_reg <= opa * opb;
        end
        case (cmd.acc)
            pcc_pkg::ACC_LOAD: acc_reg <= prod_reg;
            pcc_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_reg;
            default:           acc_reg <= acc_reg;
        endcase
        case (cmd.act)
            pcc_pkg::ACT_LOAD_A: a_reg <= rd_reg;
            pcc_pkg::ACT_LOAD_B: b_reg <= rd_reg;
            pcc_pkg::ACT_DIFF:
            begin
                dx_reg <= DW'(a_reg.pos_x) - DW'(b_reg.pos_x);
                dy_reg <= DW'(a_reg.pos_y) - DW'(b_reg.pos_y);
                r_reg  <= RS'(a_reg.rad) + RS'(b_reg.rad);
            end
            pcc_pkg::ACT_DIFF2:
            begin
                dx_reg <= DW'(b_reg.pos_x) - DW'(a_reg.pos_x);
                dy_reg <= DW'(b_reg.pos_y) - DW'(a_reg.pos_y);
            end
            pcc_pkg::ACT_OV:
            begin
                ov_reg  <= r_reg - RS'(root);
                den_reg <= (root == '0) ? pcc_pkg::DIST_TENTH : {root, 1'b0};
            end
            pcc_pkg::ACT_UPD_XI: a_reg.pos_x <= pcc_pkg::sat32(SW'(a_reg.pos_x) + quot_x);
            pcc_pkg::ACT_UPD_YI: a_reg.pos_y <= pcc_pkg::sat32(SW'(a_reg.pos_y) + quot_x);
            pcc_pkg::ACT_UPD_XJ: b_reg.pos_x <= pcc_pkg::sat32(SW'(b_reg.pos_x) + quot_x);
            pcc_pkg::ACT_UPD_YJ: b_reg.pos_y <= pcc_pkg::sat32(SW'(b_reg.pos_y) + quot_x);
            pcc_pkg::ACT_UPD_VXI: nvxi_reg <= pcc_pkg::sat32(quot_x);
            pcc_pkg::ACT_UPD_VYI: nvyi_reg <= pcc_pkg::sat32(quot_x);
            pcc_pkg::ACT_UPD_VXJ: nvxj_reg <= pcc_pkg::sat32(quot_x);
            pcc_pkg::ACT_UPD_VYJ: nvyj_reg <= pcc_pkg::sat32(quot_x);
            pcc_pkg::ACT_COMMIT:
            begin
                a_reg.vel_x <= nvxi_reg;
                a_reg.vel_y <= nvyi_reg;
                b_reg.vel_x <= nvxj_reg;
                b_reg.vel_y <= nvyj_reg;
            end
            pcc_pkg::ACT_OUT:
            begin
                out_reg      <= rd_reg;
                out_last_reg <= cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.act == pcc_pkg::ACT_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign adx = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign ady = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);

    assign status.out_of_range = (adx > DW'(r_reg)) || (ady > DW'(r_reg));
    assign status.far          = acc_reg > prod_reg;
    assign status.sqrt_busy    = sqrt_busy;
    assign status.div_busy     = div_busy;
    assign status.r_zero       = r_reg == '0;
    assign status.out_busy     = out_valid_reg && !out_ready;

    assign out_word  = out_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: design/pcc_ctrl.sv
`default_nettype none

module pcc_ctrl #(
    parameter int BALLS = pcc_pkg::BALLS_DEF,
    parameter int AW    = $clog2(BALLS),
    parameter int CW    = $clog2(BALLS + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_final,
    output logic                  in_ready,
    output pcc_pkg::cmd_t         cmd,
    output logic [AW-1:0]         addr,
    input  wire pcc_pkg::status_t status
);

    typedef enum logic [4:0] {
        S_IDLE, S_RDA, S_RDB, S_LDB, S_DIFF, S_CHK, S_M1, S_M2, S_CMP, S_SQW, S_OV,
        S_PMUL, S_PDIV, S_PWAIT, S_DIFF2, S_VM1, S_VM2, S_VACC, S_VDIV, S_VWAIT,
        S_COMMIT, S_WRA, S_WRB, S_NEXT, S_ERD, S_ELD
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [1:0]    ph_reg;
    logic [CW-1:0] cnt_next;
    logic          room;
    logic          wait_done;

    assign room      = cnt_reg < CW'(BALLS);
    assign cnt_next  = cnt_reg + CW'(room);
    assign in_ready  = state_reg == S_IDLE;
    assign wait_done = (state_reg == S_PWAIT || state_reg == S_VWAIT) && !status.div_busy;

    always_comb
    begin
        cmd  = '{act: pcc_pkg::ACT_NONE, mul: pcc_pkg::MUL_NONE,
                 acc: pcc_pkg::ACC_HOLD, last: 1'b0};
        addr = i_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                addr = cnt_reg[AW-1:0];
                if (in_valid && room)
                begin
                    cmd.act = pcc_pkg::ACT_WRITE_IN;
                end
            end
            S_RDB:
            begin
                addr    = j_reg[AW-1:0];
                cmd.act = pcc_pkg::ACT_LOAD_A;
            end
            S_LDB:  cmd.act = pcc_pkg::ACT_LOAD_B;
            S_DIFF: cmd.act = pcc_pkg::ACT_DIFF;
            S_CHK:  cmd.mul = pcc_pkg::MUL_DXDX;
            S_M1:
            begin
                cmd.acc = pcc_pkg::ACC_LOAD;
                cmd.mul = pcc_pkg::MUL_DYDY;
            end
            S_M2:
            begin
                cmd.acc = pcc_pkg::ACC_ADD;
                cmd.mul = pcc_pkg::MUL_RR;
            end
            S_CMP:
            begin
                if (!status.far)
                begin
                    cmd.act = pcc_pkg::ACT_SQRT;
                end
            end
            S_OV:    cmd.act = pcc_pkg::ACT_OV;
            S_PMUL:  cmd.mul = ph_reg[0] ? pcc_pkg::MUL_DYOV : pcc_pkg::MUL_DXOV;
            S_PDIV:  cmd.act = pcc_pkg::ACT_DIV_DEN;
            S_PWAIT:
            begin
                if (wait_done)
                begin
                    case (ph_reg)
                        2'd0:    cmd.act = pcc_pkg::ACT_UPD_XI;
                        2'd1:    cmd.act = pcc_pkg::ACT_UPD_YI;
                        2'd2:    cmd.act = pcc_pkg::ACT_UPD_XJ;
                        default: cmd.act = pcc_pkg::ACT_UPD_YJ;
                    endcase
                end
            end
            S_DIFF2: cmd.act = pcc_pkg::ACT_DIFF2;
            S_VM1:
            begin
                case (ph_reg)
                    2'd0:    cmd.mul = pcc_pkg::MUL_AIX;
                    2'd1:    cmd.mul = pcc_pkg::MUL_AIY;
                    2'd2:    cmd.mul = pcc_pkg::MUL_AJX;
                    default: cmd.mul = pcc_pkg::MUL_AJY;
                endcase
            end
            S_VM2:
            begin
                cmd.acc = pcc_pkg::ACC_LOAD;
                case (ph_reg)
                    2'd0:    cmd.mul = pcc_pkg::MUL_BJX;
                    2'd1:    cmd.mul = pcc_pkg::MUL_BJY;
                    2'd2:    cmd.mul = pcc_pkg::MUL_BIX;
                    default: cmd.mul = pcc_pkg::MUL_BIY;
                endcase
            end
            S_VACC: cmd.acc = pcc_pkg::ACC_ADD;
            S_VDIV: cmd.act = pcc_pkg::ACT_DIV_R;
            S_VWAIT:
            begin
                if (wait_done)
                begin
                    case (ph_reg)
                        2'd0:    cmd.act = pcc_pkg::ACT_UPD_VXI;
                        2'd1:    cmd.act = pcc_pkg::ACT_UPD_VYI;
                        2'd2:    cmd.act = pcc_pkg::ACT_UPD_VXJ;
                        default: cmd.act = pcc_pkg::ACT_UPD_VYJ;
                    endcase
                end
            end
            S_COMMIT: cmd.act = pcc_pkg::ACT_COMMIT;
            S_WRA:    cmd.act = pcc_pkg::ACT_WRITE_A;
            S_WRB:
            begin
                addr    = j_reg[AW-1:0];
                cmd.act = pcc_pkg::ACT_WRITE_B;
            end
            S_ELD:
            begin
                if (!status.out_busy)
                begin
                    cmd.act  = pcc_pkg::ACT_OUT;
                    cmd.last = i_reg == n_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            ph_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cnt_reg <= cnt_next;
                        if (in_final)
                        begin
                            n_reg     <= cnt_next;
                            i_reg     <= '0;
                            j_reg     <= CW'(1);
                            state_reg <= (cnt_next < CW'(2)) ? S_ERD : S_RDA;
                        end
                    end
                end
                S_RDA:  state_reg <= S_RDB;
                S_RDB:  state_reg <= S_LDB;
                S_LDB:  state_reg <= S_DIFF;
                S_DIFF: state_reg <= S_CHK;
                S_CHK:  state_reg <= status.out_of_range ? S_NEXT : S_M1;
                S_M1:   state_reg <= S_M2;
                S_M2:   state_reg <= S_CMP;
                S_CMP:  state_reg <= status.far ? S_NEXT : S_SQW;
                S_SQW:
                begin
                    if (!status.sqrt_busy)
                    begin
                        state_reg <= S_OV;
                    end
                end
                S_OV:
                begin
                    ph_reg    <= '0;
                    state_reg <= S_PMUL;
                end
                S_PMUL: state_reg <= S_PDIV;
                S_PDIV: state_reg <= S_PWAIT;
                S_PWAIT:
                begin
                    if (wait_done)
                    begin
                        ph_reg <= ph_reg + 1'b1;
                        case (ph_reg)
                            2'd1:    state_reg <= S_DIFF2;
                            2'd3:    state_reg <= status.r_zero ? S_WRA : S_VM1;
                            default: state_reg <= S_PMUL;
                        endcase
                    end
                end
                S_DIFF2: state_reg <= S_PMUL;
                S_VM1:   state_reg <= S_VM2;
                S_VM2:   state_reg <= S_VACC;
                S_VACC:  state_reg <= S_VDIV;
                S_VDIV:  state_reg <= S_VWAIT;
                S_VWAIT:
                begin
                    if (wait_done)
                    begin
                        ph_reg    <= ph_reg + 1'b1;
                        state_reg <= (ph_reg == 2'd3) ? S_COMMIT : S_VM1;
                    end
                end
                S_COMMIT: state_reg <= S_WRA;
                S_WRA:    state_reg <= S_WRB;
                S_WRB:    state_reg <= S_NEXT;
                S_NEXT:
                begin
                    if (j_reg == n_reg - 1'b1)
                    begin
                        j_reg <= i_reg + CW'(2);
                        if ((CW + 1)'(i_reg) + (CW + 1)'(2) >= (CW + 1)'(n_reg))
                        begin
                            i_reg     <= '0;
                            state_reg <= S_ERD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_RDA;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_RDA;
                    end
                end
                S_ERD: state_reg <= S_ELD;
                S_ELD:
                begin
                    if (!status.out_busy)
                    begin
                        if (i_reg == n_reg - 1'b1)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_ERD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/pairwise_circle_collision_resolve.sv
// All-pairs circle collision resolver, Q16.16 positions and velocities.
// ball_in takes one circle per word (valid/ready); words are stored in order,
// up to BALLS of them, and words beyond that are dropped. A word with
// final_item set starts the resolve pass over every pair i<j and then the
// stored circles leave on ball_out, in load order, out_last on the final one.
// ball_in is ready only while the block is loading. Per pair: circles that
// do not touch are passed over after the range and distance checks; an
// overlapping pair runs the square root and then eight passes (four if the
// radius sum is zero) through the shared one-bit-per-cycle divider. Each
// word leaves through a read state and a load state; a stall on ball_out
// holds the word in the output register and pauses the emission until it
// is taken. After reset the store is empty and ball_in is ready.
`default_nettype none

module pairwise_circle_collision_resolve #(
    parameter int BALLS = pcc_pkg::BALLS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pcc_in_if.sink    ball_in,
    pcc_out_if.source ball_out
);

    localparam int AW = $clog2(BALLS);
    localparam int CW = $clog2(BALLS + 1);

    pcc_pkg::cmd_t    cmd;
    pcc_pkg::status_t status;
    pcc_pkg::ball_t   in_word;
    pcc_pkg::ball_t   out_word;
    logic [AW-1:0]    addr;
    logic             in_ready;

    assign in_word.pos_x = ball_in.pos_x;
    assign in_word.pos_y = ball_in.pos_y;
    assign in_word.vel_x = ball_in.vel_x;
    assign in_word.vel_y = ball_in.vel_y;
    assign in_word.rad   = ball_in.rad;
    assign ball_in.ready = in_ready;

    pcc_ctrl #(
        .BALLS (BALLS),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (ball_in.valid),
        .in_final (ball_in.final_item),
        .in_ready (in_ready),
        .cmd      (cmd),
        .addr     (addr),
        .status   (status)
    );

    pcc_datapath #(
        .BALLS (BALLS),
        .AW    (AW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .addr      (addr),
        .in_word   (in_word),
        .status    (status),
        .out_word  (out_word),
        .out_last  (ball_out.out_last),
        .out_valid (ball_out.valid),
        .out_ready (ball_out.ready)
    );

    assign ball_out.new_pos_x = out_word.pos_x;
    assign ball_out.new_pos_y = out_word.pos_y;
    assign ball_out.new_vel_x = out_word.vel_x;
    assign ball_out.new_vel_y = out_word.vel_y;
    assign ball_out.out_rad   = out_word.rad;

endmodule

`default_nettype wire
